[hdl/tvs_pkg.sv]
// -----------------------------------------------------------------------------
// tvs_pkg
// Shared types and widths for the tagged value sorter: the input and result
// words and the fixed field widths of the key and tag.
// -----------------------------------------------------------------------------
package tvs_pkg;

	localparam int KEY_W      = 32;
	localparam int TAG_PORT_W = 16;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key_value;
		logic [TAG_PORT_W-1:0]   tag;
		logic                    final_item;
	} item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] sorted_value;
		logic [TAG_PORT_W-1:0]   sorted_tag;
		logic                    run_end;
		logic                    overflow;
	} result_t;

endpackage

[hdl/tvs_cell.sv]
// -----------------------------------------------------------------------------
// tvs_cell
// One cell of the insertion chain: holds one (key, tag) pair, keeps the
// smaller of its own and the arriving pair, and hands the other to the right.
// Equal keys are ordered by their arrival number.
// During unload it takes the pair of its right neighbor.
// -----------------------------------------------------------------------------
module tvs_cell
	import tvs_pkg::*;
#(
	parameter int TAG_W = 16,
	parameter int SEQ_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic             ins_vld,
	input  key_t             ins_key,
	input  logic [TAG_W-1:0] ins_tag,
	input  logic [SEQ_W-1:0] ins_seq,
	input  logic             nxt_vld,
	input  key_t             nxt_key,
	input  logic [TAG_W-1:0] nxt_tag,
	input  logic [SEQ_W-1:0] nxt_seq,
	output logic             pass_vld,
	output key_t             pass_key,
	output logic [TAG_W-1:0] pass_tag,
	output logic [SEQ_W-1:0] pass_seq,
	output logic             held_vld,
	output key_t             held_key,
	output logic [TAG_W-1:0] held_tag,
	output logic [SEQ_W-1:0] held_seq
);

	logic             pass_vld_q;
	key_t             pass_key_q;
	logic [TAG_W-1:0] pass_tag_q;
	logic [SEQ_W-1:0] pass_seq_q;
	logic             held_vld_q;
	key_t             held_key_q;
	logic [TAG_W-1:0] held_tag_q;
	logic [SEQ_W-1:0] held_seq_q;
	logic             ins_first;

	// newcomer sorts ahead: smaller key, or equal key that arrived earlier
	assign ins_first = (ins_key < held_key_q) ||
		((ins_key == held_key_q) && (ins_seq < held_seq_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_vld_q <= 1'b0;
			held_vld_q <= 1'b0;
		end else if (shift) begin
			pass_vld_q <= 1'b0;
			held_vld_q <= nxt_vld;
		end else begin
			pass_vld_q <= ins_vld && held_vld_q;
			if (ins_vld) begin
				held_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			held_key_q <= nxt_key;
			held_tag_q <= nxt_tag;
			held_seq_q <= nxt_seq;
		end else if (ins_vld) begin
			if (!held_vld_q) begin
				held_key_q <= ins_key;
				held_tag_q <= ins_tag;
				held_seq_q <= ins_seq;
			end else if (ins_first) begin
				// take the newcomer, push the old pair on
				held_key_q <= ins_key;
				held_tag_q <= ins_tag;
				held_seq_q <= ins_seq;
				pass_key_q <= held_key_q;
				pass_tag_q <= held_tag_q;
				pass_seq_q <= held_seq_q;
			end else begin
				// keep the held pair, pass the newcomer on
				pass_key_q <= ins_key;
				pass_tag_q <= ins_tag;
				pass_seq_q <= ins_seq;
			end
		end
	end

	assign pass_vld = pass_vld_q;
	assign pass_key = pass_key_q;
	assign pass_tag = pass_tag_q;
	assign pass_seq = pass_seq_q;
	assign held_vld = held_vld_q;
	assign held_key = held_key_q;
	assign held_tag = held_tag_q;
	assign held_seq = held_seq_q;

endmodule

[hdl/tagged_value_sorter.sv]
// -----------------------------------------------------------------------------
// tagged_value_sorter
// Collects a set of (key, tag) words and returns them in ascending key order.
// -----------------------------------------------------------------------------
// Usage:
//   item channel: one (key_value, tag, final_item) word per accepted cycle,
//   one word per cycle while loading. The word with final_item set closes
//   the set. Words beyond MAX_ITEMS are dropped and flag overflow.
//   result channel: one word per stored pair, ascending by key; equal keys
//   keep arrival order. run_end marks the last word, overflow is set on
//   every word of a set that lost pairs.
// Flow:
//   Each accepted word ripples down a chain of MAX_ITEMS cells, one cell per
//   cycle, so after the final word the chain drains before unload starts.
//   The sorted run then shifts out of cell 0 at one word per cycle while the
//   result is not stalled; item_stall is high during drain and unload.
// Reset clears all valid bits and counters; no clearing pass is needed.
// A stalled result holds in the output register and freezes the chain; the
// next set may start loading while the last result waits to be taken.
// -----------------------------------------------------------------------------
module tagged_value_sorter
	import tvs_pkg::*;
#(
	parameter int MAX_ITEMS = 64,
	parameter int TAG_BITS  = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_DRAIN  = 2'd1;
	localparam logic [1:0] ST_UNLOAD = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] drain_q;
	logic             drop_q;

	logic             ins_vld_s1;
	key_t             ins_key_s1;
	logic [TAG_W-1:0] ins_tag_s1;
	logic [CNT_W-1:0] ins_seq_s1;

	logic             result_valid_q;
	result_t          result_q;

	logic accept;
	logic store;
	logic load;

	// chain wiring: index j feeds cell j; index MAX_ITEMS is the open end
	logic             ins_vld [MAX_ITEMS+1];
	key_t             ins_key [MAX_ITEMS+1];
	logic [TAG_W-1:0] ins_tag [MAX_ITEMS+1];
	logic [CNT_W-1:0] ins_seq [MAX_ITEMS+1];
	logic             held_vld[MAX_ITEMS+1];
	key_t             held_key[MAX_ITEMS+1];
	logic [TAG_W-1:0] held_tag[MAX_ITEMS+1];
	logic [CNT_W-1:0] held_seq[MAX_ITEMS+1];

	assign accept = item_valid && !item_stall;
	assign store  = accept && (fill_q != CNT_MAX);
	// take the next sorted word when the output register is free
	assign load   = (state_q == ST_UNLOAD) && (!result_valid_q || !result_stall);

	assign item_stall = (state_q != ST_LOAD);

	// register the incoming pair before it enters the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_vld_s1 <= 1'b0;
		end else begin
			ins_vld_s1 <= store;
		end
	end

	// number each stored pair by arrival so equal keys keep their order
	always_ff @(posedge clk) begin
		if (store) begin
			ins_key_s1 <= item.key_value;
			ins_tag_s1 <= item.tag[TAG_W-1:0];
			ins_seq_s1 <= fill_q;
		end
	end

	// load, drain and unload sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			drain_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store) begin
							fill_q <= fill_q + CNT_ONE;
						end else begin
							drop_q <= 1'b1;
						end
						if (item.final_item) begin
							state_q <= ST_DRAIN;
							drain_q <= '0;
						end
					end
				end
				ST_DRAIN: begin
					// wait until the last pair has settled in its cell
					if (drain_q == CNT_MAX) begin
						state_q <= ST_UNLOAD;
					end else begin
						drain_q <= drain_q + CNT_ONE;
					end
				end
				ST_UNLOAD: begin
					if (load) begin
						fill_q <= fill_q - CNT_ONE;
						if (fill_q == CNT_ONE) begin
							state_q <= ST_LOAD;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register: hold a stalled word, refill from cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.sorted_value <= held_key[0];
			result_q.sorted_tag   <= TAG_PORT_W'(held_tag[0]);
			result_q.run_end      <= (fill_q == CNT_ONE);
			result_q.overflow     <= drop_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign ins_vld[0] = ins_vld_s1;
	assign ins_key[0] = ins_key_s1;
	assign ins_tag[0] = ins_tag_s1;
	assign ins_seq[0] = ins_seq_s1;

	// empty pair shifts in at the far end during unload
	assign held_vld[MAX_ITEMS] = 1'b0;
	assign held_key[MAX_ITEMS] = '0;
	assign held_tag[MAX_ITEMS] = '0;
	assign held_seq[MAX_ITEMS] = '0;

	for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
		tvs_cell #(
			.TAG_W (TAG_W),
			.SEQ_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (load),
			.ins_vld  (ins_vld[j]),
			.ins_key  (ins_key[j]),
			.ins_tag  (ins_tag[j]),
			.ins_seq  (ins_seq[j]),
			.nxt_vld  (held_vld[j+1]),
			.nxt_key  (held_key[j+1]),
			.nxt_tag  (held_tag[j+1]),
			.nxt_seq  (held_seq[j+1]),
			.pass_vld (ins_vld[j+1]),
			.pass_key (ins_key[j+1]),
			.pass_tag (ins_tag[j+1]),
			.pass_seq (ins_seq[j+1]),
			.held_vld (held_vld[j]),
			.held_key (held_key[j]),
			.held_tag (held_tag[j]),
			.held_seq (held_seq[j])
		);
	end

endmodule
